### src/sbsr_pkg.sv
// Shared types and constants for the single-wire sensor reader.
// Holds the configuration and result structs, register indexes and error codes.
// No dependencies.
`default_nettype none

package sbsr_pkg;

    // Width of the received frame (five bytes)
    localparam int FRAME_W        = 40;
    localparam int FRAME_BITS_DEF = 40;

    // Configuration register indexes and reset values
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_ADDR_W-1:0] CFG_START_LOW   = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_ACK_TIMEOUT = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_ONE_THRESH  = 2'd2;
    localparam logic [15:0] START_LOW_RST   = 16'd1000;
    localparam logic [15:0] ACK_TIMEOUT_RST = 16'd10000;
    localparam logic [7:0]  ONE_THRESH_RST  = 8'd55;

    // Error codes
    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_NO_ACK_LO = 3'd1;
    localparam logic [2:0] ERR_NO_ACK_HI = 3'd2;
    localparam logic [2:0] ERR_NO_FINAL  = 3'd3;
    localparam logic [2:0] ERR_CHECKSUM  = 3'd4;

    // Stream widths
    localparam int IN_TDATA_W  = 8;
    localparam int RES_W       = 39;
    localparam int OUT_TDATA_W = 40;

    typedef struct packed {
        logic [15:0] start_low;
        logic [15:0] ack_timeout;
        logic [7:0]  one_thresh;
    } cfg_t;

    // Last member sits in the lowest bits
    typedef struct packed {
        logic [15:0]        hum_tenths;
        logic signed [15:0] temperature_x10;
        logic [2:0]         err_code;
        logic               valid_res;
        logic               done_res;
        logic               busy_res;
        logic               drive_low;
    } res_t;

endpackage

`default_nettype wire

### src/single_bus_sensor_reader.sv
// Single-wire humidity and temperature sensor reader, one line tick per request.
// Result path: input register, then the sequencer step into the output buffer head on offer.
// Throughput: one request per cycle while the output buffer has room, set by the single-step sequencer update.
// A two-entry output buffer keeps input flowing while a result waits.
// Reset (aresetn low, synchronous): idle, counters and results zero, registers to defaults.
// Depends on sbsr_pkg, sbsr_fsm and sbsr_out_buf.
`default_nettype none

module single_bus_sensor_reader
    import sbsr_pkg::*;
#(
    parameter int FRAME_BITS = FRAME_BITS_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // Configuration write port
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    // Input stream
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [IN_TDATA_W-1:0] s_tdata,   // [0] line_level, [1] start_req, rest zero
    // Result stream
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // [0] drive_low, [1] busy_res, [2] done_res, [3] valid_res, [6:4] err_code,
    // [22:7] temperature_x10, [38:23] hum_tenths, [39] zero
    output logic [OUT_TDATA_W-1:0]     m_tdata
);

    cfg_t cfg_reg;
    logic in_valid_reg;
    logic in_level_reg;
    logic in_start_reg;
    logic s_accept;
    logic step;
    logic buf_space;
    res_t res;
    res_t out_res;

    // Configuration register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.start_low   <= START_LOW_RST;
            cfg_reg.ack_timeout <= ACK_TIMEOUT_RST;
            cfg_reg.one_thresh  <= ONE_THRESH_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                CFG_START_LOW:   cfg_reg.start_low   <= cfg_wdata;
                CFG_ACK_TIMEOUT: cfg_reg.ack_timeout <= cfg_wdata;
                CFG_ONE_THRESH:  cfg_reg.one_thresh  <= cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    // Input register: advance when the output buffer has room
    assign step     = in_valid_reg && buf_space;
    assign s_tready = !in_valid_reg || step;
    assign s_accept = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_accept) begin
            in_valid_reg <= 1'b1;
        end else if (step) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_level_reg <= s_tdata[0];
            in_start_reg <= s_tdata[1];
        end
    end

    sbsr_fsm #(
        .FRAME_BITS (FRAME_BITS)
    ) u_fsm (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step       (step),
        .line_level (in_level_reg),
        .start_req  (in_start_reg),
        .cfg        (cfg_reg),
        .res        (res)
    );

    sbsr_out_buf u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (step),
        .push_data (res),
        .space     (buf_space),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_data    (out_res)
    );

    assign m_tdata = {{(OUT_TDATA_W - RES_W){1'b0}}, out_res};

endmodule

`default_nettype wire

### src/sbsr_fsm.sv
// Protocol sequencer for the single-wire sensor reader: one line tick per step.
// Depends on sbsr_pkg for the configuration and result types.
`default_nettype none

module sbsr_fsm
    import sbsr_pkg::*;
#(
    parameter int FRAME_BITS = FRAME_BITS_DEF
) (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic step,
    input  wire logic line_level,
    input  wire logic start_req,
    input  wire cfg_t cfg,
    output res_t      res
);

    localparam int BC_W = $clog2(FRAME_BITS + 1);

    localparam logic [3:0] PH_IDLE        = 4'd0;
    localparam logic [3:0] PH_START       = 4'd1;
    localparam logic [3:0] PH_ACK_LOW     = 4'd2;
    localparam logic [3:0] PH_ACK_HIGH    = 4'd3;
    localparam logic [3:0] PH_ACK_FINAL   = 4'd4;
    localparam logic [3:0] PH_BIT_HIGH    = 4'd5;
    localparam logic [3:0] PH_BIT_MEASURE = 4'd6;

    logic [3:0]         phase_reg, phase_next;
    logic [15:0]        tick_reg, tick_next;
    logic [BC_W-1:0]    bit_cnt_reg, bit_cnt_next;
    logic [FRAME_W-1:0] frame_reg, frame_next;
    logic [15:0]        temp_reg, temp_next;
    logic [15:0]        hum_reg, hum_next;
    logic               valid_reg, valid_next;
    logic [2:0]         err_reg, err_next;
    logic               done;

    logic [16:0]     tick_inc;
    logic [BC_W-1:0] bit_cnt_inc;
    logic            new_bit;
    logic [FRAME_W-1:0] shifted;
    logic [7:0]  b0, b1, b2, b3, b4;
    logic [7:0]  csum;
    logic [15:0] raw_temp;
    logic [15:0] mag;

    assign tick_inc    = {1'b0, tick_reg} + 17'd1;
    assign bit_cnt_inc = bit_cnt_reg + BC_W'(1);
    assign new_bit     = (tick_reg >= {8'd0, cfg.one_thresh});
    assign shifted     = {frame_reg[FRAME_W-2:0], new_bit};

    // Decode the frame as it will stand after the final bit
    assign b0       = shifted[39:32];
    assign b1       = shifted[31:24];
    assign b2       = shifted[23:16];
    assign b3       = shifted[15:8];
    assign b4       = shifted[7:0];
    assign csum     = b0 + b1 + b2 + b3;
    assign raw_temp = {b2, b3};
    assign mag      = {1'b0, raw_temp[14:0]};

    // Next state for one tick
    always_comb begin
        phase_next   = phase_reg;
        tick_next    = tick_reg;
        bit_cnt_next = bit_cnt_reg;
        frame_next   = frame_reg;
        temp_next    = temp_reg;
        hum_next     = hum_reg;
        valid_next   = valid_reg;
        err_next     = err_reg;
        done         = 1'b0;
        unique case (phase_reg)
            PH_IDLE: begin
                if (start_req) begin
                    phase_next   = PH_START;
                    tick_next    = '0;
                    bit_cnt_next = '0;
                    frame_next   = '0;
                    valid_next   = 1'b0;
                end
            end
            PH_START: begin
                if (tick_inc >= {1'b0, cfg.start_low}) begin
                    phase_next = PH_ACK_LOW;
                    tick_next  = '0;
                end else begin
                    tick_next = tick_inc[15:0];
                end
            end
            PH_ACK_LOW, PH_ACK_HIGH, PH_ACK_FINAL: begin
                // Wait for the acknowledge level: low, high, then low
                if (line_level == (phase_reg == PH_ACK_HIGH)) begin
                    phase_next = phase_reg + 4'd1;
                    tick_next  = '0;
                end else if (tick_inc >= {1'b0, cfg.ack_timeout}) begin
                    phase_next = PH_IDLE;
                    tick_next  = '0;
                    valid_next = 1'b0;
                    done       = 1'b1;
                    if (phase_reg == PH_ACK_LOW) begin
                        err_next = ERR_NO_ACK_LO;
                    end else if (phase_reg == PH_ACK_HIGH) begin
                        err_next = ERR_NO_ACK_HI;
                    end else begin
                        err_next = ERR_NO_FINAL;
                    end
                end else begin
                    tick_next = tick_inc[15:0];
                end
            end
            PH_BIT_HIGH: begin
                if (line_level) begin
                    phase_next = PH_BIT_MEASURE;
                    tick_next  = 16'd1;
                end
            end
            PH_BIT_MEASURE: begin
                if (line_level) begin
                    // Saturate the high length
                    if (tick_reg != 16'hFFFF) begin
                        tick_next = tick_inc[15:0];
                    end
                end else begin
                    frame_next   = shifted;
                    bit_cnt_next = bit_cnt_inc;
                    tick_next    = '0;
                    if (bit_cnt_inc >= BC_W'(FRAME_BITS)) begin
                        phase_next   = PH_IDLE;
                        bit_cnt_next = '0;
                        done         = 1'b1;
                        hum_next     = {b0, b1};
                        temp_next    = raw_temp[15] ? (16'd0 - mag) : mag;
                        if (csum != b4) begin
                            valid_next = 1'b0;
                            err_next   = ERR_CHECKSUM;
                        end else begin
                            valid_next = 1'b1;
                            err_next   = ERR_NONE;
                        end
                    end else begin
                        phase_next = PH_BIT_HIGH;
                    end
                end
            end
            default: begin
                phase_next = PH_IDLE;
                tick_next  = '0;
            end
        endcase
    end

    // Advance the state on each processed tick
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_IDLE;
            tick_reg    <= '0;
            bit_cnt_reg <= '0;
            frame_reg   <= '0;
            temp_reg    <= '0;
            hum_reg     <= '0;
            valid_reg   <= 1'b0;
            err_reg     <= ERR_NONE;
        end else if (step) begin
            phase_reg   <= phase_next;
            tick_reg    <= tick_next;
            bit_cnt_reg <= bit_cnt_next;
            frame_reg   <= frame_next;
            temp_reg    <= temp_next;
            hum_reg     <= hum_next;
            valid_reg   <= valid_next;
            err_reg     <= err_next;
        end
    end

    // Result shows the state after this tick
    always_comb begin
        res                 = '0;
        res.drive_low       = (phase_next == PH_START);
        res.busy_res        = (phase_next != PH_IDLE);
        res.done_res        = done;
        res.valid_res       = valid_next;
        res.err_code        = err_next;
        res.temperature_x10 = temp_next;
        res.hum_tenths      = hum_next;
    end

    // A finished reading leaves the sequencer idle
    assert property (@(posedge aclk) disable iff (!aresetn)
        (step && done) |=> (phase_reg == PH_IDLE))
        else $error("sequencer not idle after a reading ended");

    // A good reading never carries an error code
    assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg |-> (err_reg == ERR_NONE))
        else $error("valid reading with an error code");

    // The request pulse always starts with an empty bit count
    assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_START) |-> (bit_cnt_reg == '0))
        else $error("bit count not cleared during request pulse");

endmodule

`default_nettype wire

### src/sbsr_out_buf.sv
// Two-entry output buffer for the sensor reader result stream.
// Depends on sbsr_pkg for the result type.
`default_nettype none

module sbsr_out_buf
    import sbsr_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic push,
    input  wire res_t push_data,
    output logic      space,
    output logic      m_tvalid,
    input  wire logic m_tready,
    output res_t      m_data
);

    res_t head_reg, tail_reg;
    logic head_valid_reg, tail_valid_reg;
    logic pop;

    assign pop      = head_valid_reg && m_tready;
    assign space    = !tail_valid_reg;
    assign m_tvalid = head_valid_reg;
    assign m_data   = head_reg;

    // Control: head holds the result on offer, tail catches the one behind
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_valid_reg <= 1'b0;
            tail_valid_reg <= 1'b0;
        end else if (pop) begin
            head_valid_reg <= tail_valid_reg || push;
            tail_valid_reg <= tail_valid_reg && push;
        end else if (push) begin
            head_valid_reg <= 1'b1;
            tail_valid_reg <= head_valid_reg;
        end
    end

    // Payload moves without reset
    always_ff @(posedge aclk) begin
        if (pop) begin
            head_reg <= tail_valid_reg ? tail_reg : push_data;
            if (tail_valid_reg && push) begin
                tail_reg <= push_data;
            end
        end else if (push) begin
            if (head_valid_reg) begin
                tail_reg <= push_data;
            end else begin
                head_reg <= push_data;
            end
        end
    end

    // Tail is only occupied behind a full head
    assert property (@(posedge aclk) disable iff (!aresetn)
        tail_valid_reg |-> head_valid_reg)
        else $error("tail entry held with empty head");

    // A waiting result stays on offer until taken
    assert property (@(posedge aclk) disable iff (!aresetn)
        (head_valid_reg && !m_tready) |=> (head_valid_reg && $stable(head_reg)))
        else $error("stalled result changed");

endmodule

`default_nettype wire

### test/tb_top.sv
// Testbench for the single-wire sensor reader: drives sampled line ticks as requests,
// predicts every status word and checks it against the result stream.
// Depends on sbsr_pkg and single_bus_sensor_reader.

module tb_top;
    import sbsr_pkg::*;

    localparam int unsigned LIMIT_CYCLES = 200_000;
    localparam int unsigned TAIL_CYCLES  = 8;
    localparam int unsigned DRAIN_LIMIT  = 20_000;
    localparam int unsigned HOLD_AT      = 300;
    localparam int unsigned HOLD_LEN     = 400;
    localparam int unsigned RANDOM_TICKS = 200;
    localparam int unsigned REPORT_MAX   = 10;

    typedef enum logic [3:0] {
        RD_IDLE, RD_START, RD_ACK_LOW, RD_ACK_HIGH, RD_ACK_FINAL, RD_BIT_WAIT, RD_BIT_MEASURE
    } rd_phase_e;

    typedef enum int {STAGE_NONE, STAGE_ACK_LOW, STAGE_ACK_HIGH, STAGE_ACK_FINAL} ack_stage_e;
    typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_BURSTY} rx_mode_e;

    // Predicts the reader's status word for every accepted tick and holds it until it arrives
    class reading_scoreboard;
        logic [15:0] start_low;
        logic [15:0] ack_timeout;
        logic [7:0]  one_thresh;
        rd_phase_e   ph;
        logic [15:0] ticks;
        int unsigned nbits;
        logic [39:0] frame;
        logic [15:0] temp_tenths;
        logic [15:0] hum_x10;
        logic        valid;
        logic [2:0]  err;
        res_t        expected_status[$];
        int unsigned fails;

        function new();
            start_low   = START_LOW_RST;
            ack_timeout = ACK_TIMEOUT_RST;
            one_thresh  = ONE_THRESH_RST;
            ph          = RD_IDLE;
            ticks       = '0;
            nbits       = 0;
            frame       = '0;
            temp_tenths = '0;
            hum_x10     = '0;
            valid       = 1'b0;
            err         = ERR_NONE;
            fails       = 0;
        endfunction

        function void load_register(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
            case (addr)
                CFG_START_LOW:   start_low   = data;
                CFG_ACK_TIMEOUT: ack_timeout = data;
                CFG_ONE_THRESH:  one_thresh  = data[7:0];
                default: ;
            endcase
        endfunction

        // Advance on the wanted level, otherwise count towards the timeout
        function logic ack_step(logic lvl, logic want, rd_phase_e nxt, logic [2:0] code);
            if (lvl == want) begin
                ph    = nxt;
                ticks = '0;
                return 1'b0;
            end
            ticks = ticks + 16'd1;
            if (ticks >= ack_timeout) begin
                ph    = RD_IDLE;
                ticks = '0;
                valid = 1'b0;
                err   = code;
                return 1'b1;
            end
            return 1'b0;
        endfunction

        function void note_tick(logic lvl, logic st);
            logic        done;
            logic [7:0]  csum;
            logic [15:0] raw;
            res_t        r;
            done = 1'b0;
            case (ph)
                RD_IDLE: if (st) begin
                    ph    = RD_START;
                    ticks = '0;
                    nbits = 0;
                    frame = '0;
                    valid = 1'b0;
                end
                RD_START: begin
                    ticks = ticks + 16'd1;
                    if (ticks >= start_low) begin
                        ph    = RD_ACK_LOW;
                        ticks = '0;
                    end
                end
                RD_ACK_LOW:   done = ack_step(lvl, 1'b0, RD_ACK_HIGH, ERR_NO_ACK_LO);
                RD_ACK_HIGH:  done = ack_step(lvl, 1'b1, RD_ACK_FINAL, ERR_NO_ACK_HI);
                RD_ACK_FINAL: done = ack_step(lvl, 1'b0, RD_BIT_WAIT, ERR_NO_FINAL);
                RD_BIT_WAIT: if (lvl) begin
                    ph    = RD_BIT_MEASURE;
                    ticks = 16'd1;
                end
                RD_BIT_MEASURE: if (lvl) begin
                    if (ticks != 16'hFFFF)
                        ticks = ticks + 16'd1;
                end else begin
                    // A falling edge closes the pulse; shift the bit in MSB first
                    frame = {frame[38:0], ticks >= one_thresh};
                    nbits = nbits + 1;
                    ticks = '0;
                    if (nbits >= FRAME_W) begin
                        raw         = frame[23:8];
                        hum_x10     = frame[39:24];
                        temp_tenths = raw[15] ? -{1'b0, raw[14:0]} : {1'b0, raw[14:0]};
                        csum        = frame[39:32] + frame[31:24] + frame[23:16] + frame[15:8];
                        if (csum != frame[7:0]) begin
                            valid = 1'b0;
                            err   = ERR_CHECKSUM;
                        end else begin
                            valid = 1'b1;
                            err   = ERR_NONE;
                        end
                        ph    = RD_IDLE;
                        nbits = 0;
                        done  = 1'b1;
                    end else begin
                        ph = RD_BIT_WAIT;
                    end
                end
                default: begin
                    ph    = RD_IDLE;
                    ticks = '0;
                end
            endcase
            r.drive_low       = (ph == RD_START);
            r.busy_res        = (ph != RD_IDLE);
            r.done_res        = done;
            r.valid_res       = valid;
            r.err_code        = err;
            r.temperature_x10 = temp_tenths;
            r.hum_tenths      = hum_x10;
            expected_status.push_back(r);
        endfunction

        function void check_status(logic [OUT_TDATA_W-1:0] word);
            res_t got;
            res_t want;
            got = word[RES_W-1:0];
            if (expected_status.size() == 0) begin
                fails++;
                if (fails <= REPORT_MAX)
                    $display("status word %h arrived with nothing outstanding", word);
                return;
            end
            want = expected_status.pop_front();
            if (got !== want || word[OUT_TDATA_W-1:RES_W] !== '0) begin
                fails++;
                if (fails <= REPORT_MAX) begin
                    $display("status mismatch (expected/actual): drive_low %b/%b busy %b/%b",
                             want.drive_low, got.drive_low, want.busy_res, got.busy_res);
                    $display("  done %b/%b valid %b/%b err %0d/%0d temp %0d/%0d",
                             want.done_res, got.done_res, want.valid_res, got.valid_res,
                             want.err_code, got.err_code,
                             want.temperature_x10, got.temperature_x10);
                    $display("  hum %0d/%0d pad %b",
                             want.hum_tenths, got.hum_tenths, word[OUT_TDATA_W-1:RES_W]);
                end
            end
        endfunction
    endclass

    logic                   aclk;
    logic                   aresetn   = 1'b0;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0]  cfg_addr  = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;

    reading_scoreboard sb = new();
    int unsigned burst_left = 0;
    int unsigned ticks_sent = 0;

    single_bus_sensor_reader dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Offer one tick, in bursts of random length with random gaps between them
    task automatic send_tick(input logic lvl, input logic st);
        int unsigned gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 4);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(200, 2000)
                                                     : $urandom_range(4, 40);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= IN_TDATA_W'({st, lvl});
        do @(posedge aclk); while (!s_tready);
        sb.note_tick(lvl, st);
        burst_left--;
        ticks_sent++;
    endtask

    // Toggle the line until any reading in progress has ended
    task automatic settle_reader();
        logic lvl;
        lvl = 1'b1;
        while (sb.ph != RD_IDLE) begin
            send_tick(lvl, 1'b0);
            lvl = ~lvl;
        end
    endtask

    task automatic write_register(input logic [CFG_ADDR_W-1:0] addr,
                                  input logic [CFG_DATA_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= data;
        @(posedge aclk);
        sb.load_register(addr, data);
    endtask

    // Write all registers once the reader is idle and every status word is back
    task automatic set_config(input logic [15:0] sl, input logic [15:0] at, input logic [7:0] th);
        settle_reader();
        s_tvalid <= 1'b0;
        while (sb.expected_status.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
        write_register(CFG_START_LOW, sl);
        write_register(CFG_ACK_TIMEOUT, at);
        write_register(CFG_ONE_THRESH, {8'd0, th});
        cfg_wr_en <= 1'b0;
    endtask

    function automatic logic [39:0] build_frame(logic [15:0] hum, logic [15:0] temp_raw,
                                                bit corrupt);
        logic [7:0] sum;
        sum = hum[15:8] + hum[7:0] + temp_raw[15:8] + temp_raw[7:0];
        if (corrupt)
            sum = sum ^ 8'($urandom_range(1, 255));
        return {hum, temp_raw, sum};
    endfunction

    // Play a sensor: request pulse, acknowledge (or a stalled one), then 40 timed pulses
    task automatic run_reading(input logic [39:0] bits, input ack_stage_e fail_at);
        ack_stage_e  stages[3];
        int unsigned span;
        int unsigned slack;
        int unsigned thr;
        int unsigned hi_len;
        logic        want;
        stages = '{STAGE_ACK_LOW, STAGE_ACK_HIGH, STAGE_ACK_FINAL};
        settle_reader();
        span  = (sb.ack_timeout == 0) ? 1 : sb.ack_timeout;
        slack = (span > 6) ? 6 : span - 1;
        thr   = (sb.one_thresh == 0) ? 1 : sb.one_thresh;
        send_tick(1'($urandom_range(0, 1)), 1'b1);
        // Line and start are ignored while the request pulse is driven
        repeat ((sb.start_low == 0) ? 1 : sb.start_low)
            send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        foreach (stages[i]) begin
            want = (stages[i] == STAGE_ACK_HIGH);
            if (fail_at == stages[i]) begin
                repeat (span) send_tick(~want, 1'($urandom_range(0, 1)));
                return;
            end
            repeat (($urandom_range(0, 3) == 0) ? slack : $urandom_range(0, slack))
                send_tick(~want, 1'($urandom_range(0, 1)));
            send_tick(want, 1'($urandom_range(0, 1)));
        end
        for (int i = 39; i >= 0; i--) begin
            repeat ($urandom_range(0, 2)) send_tick(1'b0, 1'($urandom_range(0, 1)));
            if (bits[i])
                hi_len = thr + (($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 3));
            else
                hi_len = (thr > 1) ? $urandom_range(1, thr - 1) : 1;
            repeat (hi_len) send_tick(1'b1, 1'($urandom_range(0, 1)));
            send_tick(1'b0, 1'($urandom_range(0, 1)));
        end
    endtask

    // Receiver: change stall pattern now and then, and hold off once for a long stretch
    initial begin
        int unsigned n_rcv;
        int unsigned mode_left;
        rx_mode_e    mode;
        n_rcv     = 0;
        mode_left = 0;
        mode      = RX_OPEN;
        while (!aresetn) @(posedge aclk);
        forever begin
            @(posedge aclk);
            n_rcv++;
            if (n_rcv == HOLD_AT) begin
                m_tready <= 1'b0;
                repeat (HOLD_LEN) @(posedge aclk);
            end
            if (mode_left == 0) begin
                mode      = rx_mode_e'($urandom_range(0, 3));
                mode_left = $urandom_range(32, 400);
            end
            mode_left--;
            case (mode)
                RX_OPEN:   m_tready <= 1'b1;
                RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
                RX_SPARSE: m_tready <= (n_rcv % 4 == 0);
                default:   m_tready <= (n_rcv % 5 < 3);
            endcase
        end
    end

    // Check every accepted status word
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_status(m_tdata);
    end

    initial begin
        repeat (LIMIT_CYCLES) @(posedge aclk);
        $display("timeout after %0d cycles", LIMIT_CYCLES);
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        int unsigned first_random;
        int unsigned waited;
        int unsigned pick;
        logic [15:0] temp_raw;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Short timings: negative zero, bad checksum, each handshake stall
        set_config(16'd2, 16'd4, 8'd3);
        run_reading(build_frame(16'd655, 16'h8000, 1'b0), STAGE_NONE);
        run_reading(build_frame(16'd1000, 16'h7FFF, 1'b1), STAGE_NONE);
        run_reading(build_frame(16'd500, 16'h00FA, 1'b0), STAGE_ACK_LOW);
        run_reading(build_frame(16'd500, 16'h00FA, 1'b0), STAGE_ACK_HIGH);
        run_reading(build_frame(16'd500, 16'h00FA, 1'b0), STAGE_ACK_FINAL);
        repeat (4) send_tick(1'($urandom_range(0, 1)), 1'b0);

        // Zero registers behave as one: full-scale humidity, most negative temperature
        set_config(16'd0, 16'd0, 8'd0);
        run_reading(build_frame(16'hFFFF, 16'hFFFF, 1'b0), STAGE_NONE);
        run_reading(build_frame(16'($urandom), 16'($urandom), 1'b0), STAGE_ACK_HIGH);
        set_config(16'd1, 16'd1, 8'd1);
        run_reading(build_frame(16'($urandom), 16'($urandom), 1'b0), STAGE_ACK_FINAL);

        // Random: mostly well-formed readings, some stalls and line noise
        first_random = ticks_sent;
        while (ticks_sent - first_random < RANDOM_TICKS) begin
            if ($urandom_range(0, 2) == 0)
                set_config(16'($urandom_range(1, 8)), 16'($urandom_range(1, 12)),
                           8'($urandom_range(1, 6)));
            pick     = $urandom_range(0, 9);
            temp_raw = ($urandom_range(0, 7) == 0) ? 16'h8000 : 16'($urandom);
            if (pick < 7)
                run_reading(build_frame(16'($urandom), temp_raw, pick == 0), STAGE_NONE);
            else if (pick == 7)
                run_reading(build_frame(16'($urandom), temp_raw, 1'b0),
                            ack_stage_e'($urandom_range(1, 3)));
            else
                repeat ($urandom_range(10, 60))
                    send_tick(1'($urandom_range(0, 1)), $urandom_range(0, 3) == 0);
        end

        // Drain and finish
        s_tvalid <= 1'b0;
        waited = 0;
        while (sb.expected_status.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (sb.expected_status.size() != 0)
            $display("%0d status words never arrived", sb.expected_status.size());
        if (sb.fails == 0 && sb.expected_status.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
